// File: sv/bcomp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_pkg
// Shared types and constants of the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bcomp_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 24;
    localparam int DT_W      = 25;
    localparam int PROD_W    = 42;
    localparam int OFF_W     = 36;
    localparam int SENS_W    = 35;
    localparam int SENS_LO_W = 18;
    localparam int FULL_W    = 60;
    localparam int DIFF_W    = 40;
    localparam int CFG_IDX_W = 3;

    localparam logic [RAW_W-1:0] RAW_ALL_ONES = '1;

    localparam logic signed [TEMP_W:0] TEMP_OFFSET  = 20'sd29315;
    localparam logic signed [TEMP_W:0] TEMP_MIN_EXT = -20'sd131072;
    localparam logic signed [TEMP_W:0] TEMP_MAX_EXT = 20'sd262143;
    localparam logic signed [PRES_W:0] PRES_MIN_EXT = -25'sd8388608;
    localparam logic signed [PRES_W:0] PRES_MAX_EXT = 25'sd8388607;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOT_CAL = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROM_WORD_ZERO = 3'd0,
        REG_COEF_SENS      = 3'd1,
        REG_COEF_OFFSET    = 3'd2,
        REG_COEF_SENS_TC   = 3'd3,
        REG_COEF_OFFSET_TC = 3'd4,
        REG_COEF_TREF      = 3'd5,
        REG_COEF_TEMPSENS  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] prom_word_zero;
        logic [COEF_W-1:0] coef_sens;
        logic [COEF_W-1:0] coef_offset;
        logic [COEF_W-1:0] coef_sens_tc;
        logic [COEF_W-1:0] coef_offset_tc;
        logic [COEF_W-1:0] coef_tref;
        logic [COEF_W-1:0] coef_tempsens;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp_ck;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } front_t;

    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic signed [TEMP_W-1:0] temp_ck;
        logic signed [PRES_W-1:0] pressure_pa;
    } res_t;

endpackage

// File: sv/bcomp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_cfg
// Calibration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bcomp_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcomp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcomp_pkg::COEF_W-1:0]       cfg_wdata,
    output bcomp_pkg::cfg_t                    cfg
);

    bcomp_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bcomp_pkg::REG_PROM_WORD_ZERO: cfg_next.prom_word_zero = cfg_wdata;
                bcomp_pkg::REG_COEF_SENS:      cfg_next.coef_sens      = cfg_wdata;
                bcomp_pkg::REG_COEF_OFFSET:    cfg_next.coef_offset    = cfg_wdata;
                bcomp_pkg::REG_COEF_SENS_TC:   cfg_next.coef_sens_tc   = cfg_wdata;
                bcomp_pkg::REG_COEF_OFFSET_TC: cfg_next.coef_offset_tc = cfg_wdata;
                bcomp_pkg::REG_COEF_TREF:      cfg_next.coef_tref      = cfg_wdata;
                bcomp_pkg::REG_COEF_TEMPSENS:  cfg_next.coef_tempsens  = cfg_wdata;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/bcomp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_front
// First three stages: dT, the three coefficient products, then TEMP, OFF
// and SENS.
// ----------------------------------------------------------------------------
module bcomp_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [bcomp_pkg::RAW_W-1:0]     d1,
    input  logic [bcomp_pkg::RAW_W-1:0]     d2,
    input  bcomp_pkg::cfg_t                 cfg,
    output bcomp_pkg::front_t               front
);

    // stage 1
    logic                                   v1_reg;
    logic signed [bcomp_pkg::DT_W-1:0]      dt_reg, dt_next;
    logic [bcomp_pkg::RAW_W-1:0]            d1_s1_reg;
    bcomp_pkg::status_t                     st_s1_reg, st_next;

    // stage 2
    logic                                   v2_reg;
    logic signed [bcomp_pkg::PROD_W-1:0]    prod_temp_reg, prod_temp_next;
    logic signed [bcomp_pkg::PROD_W-1:0]    prod_off_reg, prod_off_next;
    logic signed [bcomp_pkg::PROD_W-1:0]    prod_sens_reg, prod_sens_next;
    logic [bcomp_pkg::RAW_W-1:0]            d1_s2_reg;
    bcomp_pkg::status_t                     st_s2_reg;

    // stage 3
    logic                                   v3_reg;
    logic signed [bcomp_pkg::TEMP_W:0]      temp_sum;
    logic signed [bcomp_pkg::TEMP_W-1:0]    temp_reg, temp_next;
    logic signed [bcomp_pkg::OFF_W-1:0]     off_reg, off_next;
    logic signed [bcomp_pkg::SENS_W-1:0]    sens_reg, sens_next;
    logic [bcomp_pkg::RAW_W-1:0]            d1_s3_reg;
    bcomp_pkg::status_t                     st_s3_reg;

    always_comb begin
        dt_next = $signed({1'b0, d2}) - $signed({1'b0, cfg.coef_tref, 8'd0});
        if (cfg.prom_word_zero == '0) begin
            st_next = bcomp_pkg::STATUS_NOT_CAL;
        end else if (d1 == '0 || d1 == bcomp_pkg::RAW_ALL_ONES ||
                     d2 == '0 || d2 == bcomp_pkg::RAW_ALL_ONES) begin
            st_next = bcomp_pkg::STATUS_INVALID;
        end else begin
            st_next = bcomp_pkg::STATUS_OK;
        end
    end

    always_comb begin
        prod_temp_next = dt_reg * $signed({1'b0, cfg.coef_tempsens});
        prod_off_next  = dt_reg * $signed({1'b0, cfg.coef_offset_tc});
        prod_sens_next = dt_reg * $signed({1'b0, cfg.coef_sens_tc});
    end

    // upper part-selects are the floor shifts by 23, 6 and 7
    always_comb begin
        temp_sum = $signed({prod_temp_reg[bcomp_pkg::PROD_W-1],
                            prod_temp_reg[bcomp_pkg::PROD_W-1:23]})
                   + bcomp_pkg::TEMP_OFFSET;
        if (temp_sum < bcomp_pkg::TEMP_MIN_EXT) begin
            temp_next = bcomp_pkg::TEMP_MIN_EXT[bcomp_pkg::TEMP_W-1:0];
        end else if (temp_sum > bcomp_pkg::TEMP_MAX_EXT) begin
            temp_next = bcomp_pkg::TEMP_MAX_EXT[bcomp_pkg::TEMP_W-1:0];
        end else begin
            temp_next = temp_sum[bcomp_pkg::TEMP_W-1:0];
        end
        off_next  = $signed({3'b000, cfg.coef_offset, 17'd0})
                    + $signed(prod_off_reg[bcomp_pkg::PROD_W-1:6]);
        sens_next = $signed({3'b000, cfg.coef_sens, 16'd0})
                    + $signed(prod_sens_reg[bcomp_pkg::PROD_W-1:7]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dt_reg        <= dt_next;
            d1_s1_reg     <= d1;
            st_s1_reg     <= st_next;
            prod_temp_reg <= prod_temp_next;
            prod_off_reg  <= prod_off_next;
            prod_sens_reg <= prod_sens_next;
            d1_s2_reg     <= d1_s1_reg;
            st_s2_reg     <= st_s1_reg;
            temp_reg      <= temp_next;
            off_reg       <= off_next;
            sens_reg      <= sens_next;
            d1_s3_reg     <= d1_s2_reg;
            st_s3_reg     <= st_s2_reg;
        end
    end

    always_comb begin
        front.valid   = v3_reg;
        front.status  = st_s3_reg;
        front.d1      = d1_s3_reg;
        front.temp_ck = temp_reg;
        front.off     = off_reg;
        front.sens    = sens_reg;
    end

endmodule

// File: sv/bcomp_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_press
// Last three stages: D1 times SENS as two partial products, the combine and
// offset subtract, then the final shift, saturation and output register.
// ----------------------------------------------------------------------------
module bcomp_press (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  bcomp_pkg::front_t   front,
    output bcomp_pkg::res_t     res
);

    // stage 4
    logic                                   v4_reg;
    logic [bcomp_pkg::PROD_W-1:0]           p_lo_reg, p_lo_next;
    logic signed [bcomp_pkg::PROD_W-1:0]    p_hi_reg, p_hi_next;
    logic signed [bcomp_pkg::OFF_W-1:0]     off_s4_reg;
    logic signed [bcomp_pkg::TEMP_W-1:0]    temp_s4_reg;
    bcomp_pkg::status_t                     st_s4_reg;

    // stage 5
    logic                                   v5_reg;
    logic signed [bcomp_pkg::FULL_W-1:0]    full;
    logic signed [bcomp_pkg::DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [bcomp_pkg::TEMP_W-1:0]    temp_s5_reg;
    bcomp_pkg::status_t                     st_s5_reg;

    // output stage
    logic                                   v6_reg;
    logic signed [bcomp_pkg::PRES_W:0]      p_wide;
    logic signed [bcomp_pkg::PRES_W-1:0]    pres_reg, pres_next;
    logic signed [bcomp_pkg::TEMP_W-1:0]    temp_reg, temp_next;
    bcomp_pkg::status_t                     st_reg;

    always_comb begin
        p_lo_next = front.d1 * front.sens[bcomp_pkg::SENS_LO_W-1:0];
        p_hi_next = $signed({1'b0, front.d1})
                    * $signed(front.sens[bcomp_pkg::SENS_W-1:bcomp_pkg::SENS_LO_W]);
    end

    // full product, then floor shift by 21 and subtract OFF
    always_comb begin
        full = $signed({p_hi_reg, {bcomp_pkg::SENS_LO_W{1'b0}}})
               + $signed({{bcomp_pkg::SENS_LO_W{1'b0}}, p_lo_reg});
        diff_next = $signed({full[bcomp_pkg::FULL_W-1], full[bcomp_pkg::FULL_W-1:21]})
                    - $signed({{(bcomp_pkg::DIFF_W-bcomp_pkg::OFF_W){off_s4_reg[bcomp_pkg::OFF_W-1]}},
                               off_s4_reg});
    end

    always_comb begin
        p_wide = $signed(diff_reg[bcomp_pkg::DIFF_W-1:15]);
        if (st_s5_reg != bcomp_pkg::STATUS_OK) begin
            pres_next = '0;
            temp_next = '0;
        end else begin
            temp_next = temp_s5_reg;
            if (p_wide < bcomp_pkg::PRES_MIN_EXT) begin
                pres_next = bcomp_pkg::PRES_MIN_EXT[bcomp_pkg::PRES_W-1:0];
            end else if (p_wide > bcomp_pkg::PRES_MAX_EXT) begin
                pres_next = bcomp_pkg::PRES_MAX_EXT[bcomp_pkg::PRES_W-1:0];
            end else begin
                pres_next = p_wide[bcomp_pkg::PRES_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= front.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_lo_reg    <= p_lo_next;
            p_hi_reg    <= p_hi_next;
            off_s4_reg  <= front.off;
            temp_s4_reg <= front.temp_ck;
            st_s4_reg   <= front.status;
            diff_reg    <= diff_next;
            temp_s5_reg <= temp_s4_reg;
            st_s5_reg   <= st_s4_reg;
            pres_reg    <= pres_next;
            temp_reg    <= temp_next;
            st_reg      <= st_s5_reg;
        end
    end

    always_comb begin
        res.valid       = v6_reg;
        res.status      = st_reg;
        res.temp_ck     = temp_reg;
        res.pressure_pa = pres_reg;
    end

endmodule

// File: sv/baro_sensor_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top
// First-order barometric sensor compensation: raw D1/D2 readings in,
// temperature in centikelvin and pressure in pascals out.
// ----------------------------------------------------------------------------
// Takes one reading pair per clock when not stalled: three stages build dT,
// the coefficient products and TEMP/OFF/SENS, three more form D1*SENS as two
// partial products, subtract OFF and saturate. The whole pipeline advances
// together, so while a result is held at the output by m_tready low, s_tready
// is low too; the depth of six stages sets the latency. Calibration registers
// are written through the cfg channel and take effect at once; the user must
// write them only with the pipeline empty, which the block does not enforce.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // pressure_raw[23:0], temperature_raw[47:24]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // temperature_ck[18:0], pressure_pa[42:19], zeros
    output logic [1:0]  m_tuser,    // status[1:0]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam logic signed [bcomp_pkg::TEMP_W-1:0] TEMP_REACH_LO = -19'sd101757;
    localparam logic signed [bcomp_pkg::TEMP_W-1:0] TEMP_REACH_HI = 19'sd160386;

    bcomp_pkg::cfg_t    cfg;
    bcomp_pkg::front_t  front;
    bcomp_pkg::res_t    res;
    logic               en;

    // stall everything while the output register holds an untaken result
    assign en       = !res.valid || m_tready;
    assign s_tready = en;

    bcomp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcomp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .d1       (s_tdata[23:0]),
        .d2       (s_tdata[47:24]),
        .cfg      (cfg),
        .front    (front)
    );

    bcomp_press u_press (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .front   (front),
        .res     (res)
    );

    assign m_tvalid = res.valid;
    assign m_tdata  = {5'b00000, res.pressure_pa, res.temp_ck};
    assign m_tuser  = res.status;

    // flagged results carry no measurement
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != bcomp_pkg::STATUS_OK
        |-> m_tdata[42:0] == '0)
        else $error("flagged result carries nonzero data");

    // temperature can only land in the band reachable from the shift by 23
    a_temp_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bcomp_pkg::STATUS_OK
        |-> $signed(m_tdata[18:0]) >= TEMP_REACH_LO &&
            $signed(m_tdata[18:0]) <= TEMP_REACH_HI)
        else $error("temperature outside reachable band");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a result appears only if the stage ahead of the output held one
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(u_press.v5_reg))
        else $error("result appeared from an empty pipeline");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for baro_sensor_compensation_top. Raw pressure/temperature pairs
// go in on the s_ stream and calibration words through the cfg channel. An
// integer model of the first-order compensation predicts each result, and a
// scoreboard compares every m_ result with the oldest prediction, field by
// field. Directed cases cover missing calibration, bad raw readings, bad
// register indexes and extreme values. Random readings then run under
// several calibrations, with idle and stall patterns on both sides, a long
// output stall and a full drain in the middle of a stream.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_CAL_REGS   = 7;
    localparam int PIPE_DEPTH     = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_ROUNDS  = 6;
    localparam int ROUND_ITEMS    = 62;

    localparam logic [bcomp_pkg::CFG_IDX_W-1:0] REG_IDX_UNUSED = 3'd7;

    localparam longint KELVIN_OFFSET_CK = 29315;
    localparam longint TEMP_LO = -131072;
    localparam longint TEMP_HI = 262143;
    localparam longint PRES_LO = -8388608;
    localparam longint PRES_HI = 8388607;

    // typical datasheet calibration and readings
    localparam logic [bcomp_pkg::COEF_W-1:0] TYP_C1 = 16'd46372;
    localparam logic [bcomp_pkg::COEF_W-1:0] TYP_C2 = 16'd43981;
    localparam logic [bcomp_pkg::COEF_W-1:0] TYP_C3 = 16'd29059;
    localparam logic [bcomp_pkg::COEF_W-1:0] TYP_C4 = 16'd27842;
    localparam logic [bcomp_pkg::COEF_W-1:0] TYP_C5 = 16'd31553;
    localparam logic [bcomp_pkg::COEF_W-1:0] TYP_C6 = 16'd28165;
    localparam logic [bcomp_pkg::RAW_W-1:0]  TYP_D1 = 24'd6465444;
    localparam logic [bcomp_pkg::RAW_W-1:0]  TYP_D2 = 24'd8077636;
    localparam logic [bcomp_pkg::RAW_W-1:0]  RAW_MAX_VALID = bcomp_pkg::RAW_ALL_ONES - 1;

    typedef struct packed {
        logic signed [bcomp_pkg::TEMP_W-1:0] temp_ck;
        logic signed [bcomp_pkg::PRES_W-1:0] pressure_pa;
        bcomp_pkg::status_t                  status;
    } compensated_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    logic [bcomp_pkg::COEF_W-1:0] cal_reg [NUM_CAL_REGS] = '{default: '0};
    compensated_t      compensated_q [$];
    int                fail_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_off_cycles = 0;
    int                quiet_cycles = 0;

    baro_sensor_compensation_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic compensated_t compensate(logic [bcomp_pkg::RAW_W-1:0] d1,
                                                logic [bcomp_pkg::RAW_W-1:0] d2);
        compensated_t r;
        longint c1, c2, c3, c4, c5, c6, d1v, d2v, dt, temp, off, sens, p;
        r.temp_ck     = '0;
        r.pressure_pa = '0;
        r.status      = bcomp_pkg::STATUS_OK;
        // missing calibration wins over a bad reading
        if (cal_reg[bcomp_pkg::REG_PROM_WORD_ZERO] == '0) begin
            r.status = bcomp_pkg::STATUS_NOT_CAL;
            return r;
        end
        if (d1 == '0 || d1 == bcomp_pkg::RAW_ALL_ONES ||
            d2 == '0 || d2 == bcomp_pkg::RAW_ALL_ONES) begin
            r.status = bcomp_pkg::STATUS_INVALID;
            return r;
        end
        c1  = longint'(cal_reg[bcomp_pkg::REG_COEF_SENS]);
        c2  = longint'(cal_reg[bcomp_pkg::REG_COEF_OFFSET]);
        c3  = longint'(cal_reg[bcomp_pkg::REG_COEF_SENS_TC]);
        c4  = longint'(cal_reg[bcomp_pkg::REG_COEF_OFFSET_TC]);
        c5  = longint'(cal_reg[bcomp_pkg::REG_COEF_TREF]);
        c6  = longint'(cal_reg[bcomp_pkg::REG_COEF_TEMPSENS]);
        d1v = longint'(d1);
        d2v = longint'(d2);
        dt   = d2v - (c5 <<< 8);
        temp = KELVIN_OFFSET_CK + ((dt * c6) >>> 23);
        off  = (c2 <<< 17) + ((c4 * dt) >>> 6);
        sens = (c1 <<< 16) + ((c3 * dt) >>> 7);
        p    = (((d1v * sens) >>> 21) - off) >>> 15;
        if (temp < TEMP_LO) temp = TEMP_LO;
        if (temp > TEMP_HI) temp = TEMP_HI;
        if (p < PRES_LO) p = PRES_LO;
        if (p > PRES_HI) p = PRES_HI;
        r.temp_ck     = temp[bcomp_pkg::TEMP_W-1:0];
        r.pressure_pa = p[bcomp_pkg::PRES_W-1:0];
        return r;
    endfunction

    // scoreboard: track config writes, predict accepted requests, check results
    always @(posedge aclk) begin
        compensated_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_CAL_REGS) begin
                cal_reg[cfg_index] = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                compensated_q.push_back(compensate(s_tdata[bcomp_pkg::RAW_W-1:0],
                                                   s_tdata[2*bcomp_pkg::RAW_W-1:bcomp_pkg::RAW_W]));
            end
            if (m_tvalid && m_tready) begin
                if (compensated_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("unexpected result: temp %0d pres %0d status %0d",
                                 $signed(m_tdata[bcomp_pkg::TEMP_W-1:0]),
                                 $signed(m_tdata[bcomp_pkg::TEMP_W+bcomp_pkg::PRES_W-1:
                                                 bcomp_pkg::TEMP_W]), m_tuser);
                    end
                end else begin
                    want = compensated_q.pop_front();
                    if (m_tdata[bcomp_pkg::TEMP_W-1:0] !== want.temp_ck ||
                        m_tdata[bcomp_pkg::TEMP_W+bcomp_pkg::PRES_W-1:bcomp_pkg::TEMP_W]
                            !== want.pressure_pa ||
                        m_tuser !== want.status) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("mismatch at %0t: temp exp %0d got %0d, pres exp %0d got %0d",
                                     $time, want.temp_ck,
                                     $signed(m_tdata[bcomp_pkg::TEMP_W-1:0]),
                                     want.pressure_pa,
                                     $signed(m_tdata[bcomp_pkg::TEMP_W+bcomp_pkg::PRES_W-1:
                                                     bcomp_pkg::TEMP_W]));
                            $display("    status exp %0d got %0d", want.status, m_tuser);
                        end
                    end
                end
            end
        end
    end

    // result side: random stalls, or a counted hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_tready = 1'b0;
            hold_off_cycles--;
        end else begin
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** baro_sensor_compensation_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_reading(logic [bcomp_pkg::RAW_W-1:0] d1,
                                logic [bcomp_pkg::RAW_W-1:0] d2);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {d2, d1};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (compensated_q.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic write_register(logic [bcomp_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bcomp_pkg::COEF_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_calibration(logic [bcomp_pkg::COEF_W-1:0] prom,
                                    logic [bcomp_pkg::COEF_W-1:0] c1,
                                    logic [bcomp_pkg::COEF_W-1:0] c2,
                                    logic [bcomp_pkg::COEF_W-1:0] c3,
                                    logic [bcomp_pkg::COEF_W-1:0] c4,
                                    logic [bcomp_pkg::COEF_W-1:0] c5,
                                    logic [bcomp_pkg::COEF_W-1:0] c6);
        write_register(bcomp_pkg::REG_PROM_WORD_ZERO, prom);
        write_register(bcomp_pkg::REG_COEF_SENS, c1);
        write_register(bcomp_pkg::REG_COEF_OFFSET, c2);
        write_register(bcomp_pkg::REG_COEF_SENS_TC, c3);
        write_register(bcomp_pkg::REG_COEF_OFFSET_TC, c4);
        write_register(bcomp_pkg::REG_COEF_TREF, c5);
        write_register(bcomp_pkg::REG_COEF_TEMPSENS, c6);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [bcomp_pkg::RAW_W-1:0] pick_raw_edge();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return bcomp_pkg::RAW_ALL_ONES;
            2:       return 24'd1;
            default: return RAW_MAX_VALID;
        endcase
    endfunction

    function automatic logic [bcomp_pkg::RAW_W-1:0] pick_pressure_raw();
        if ($urandom_range(0, 19) == 0) return pick_raw_edge();
        return 24'($urandom_range(1, 24'hFFFFFE));
    endfunction

    // half of the temperature readings sit close to the reference temperature
    function automatic logic [bcomp_pkg::RAW_W-1:0] pick_temperature_raw();
        int near_tref;
        case ($urandom_range(0, 19)) inside
            0:       return pick_raw_edge();
            [1:10]: begin
                near_tref = int'(cal_reg[bcomp_pkg::REG_COEF_TREF]) * 256
                          + int'($urandom_range(0, 131072)) - 65536;
                return near_tref[bcomp_pkg::RAW_W-1:0];
            end
            default: return 24'($urandom_range(1, 24'hFFFFFE));
        endcase
    endfunction

    function automatic logic [bcomp_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_uncalibrated();
        send_reading(TYP_D1, TYP_D2);
        send_reading('0, TYP_D2);
        send_reading(TYP_D1, bcomp_pkg::RAW_ALL_ONES);
        send_reading(bcomp_pkg::RAW_ALL_ONES, bcomp_pkg::RAW_ALL_ONES);
        wait_for_results();
    endtask

    // a write to an index past the register file must not land anywhere
    task automatic test_bad_register_index();
        write_register(REG_IDX_UNUSED, 16'hFFFF);
        send_reading(TYP_D1, TYP_D2);
        wait_for_results();
    endtask

    task automatic test_invalid_readings();
        load_calibration(16'h0001, TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
        send_reading('0, TYP_D2);
        send_reading(bcomp_pkg::RAW_ALL_ONES, TYP_D2);
        send_reading(TYP_D1, '0);
        send_reading(TYP_D1, bcomp_pkg::RAW_ALL_ONES);
        send_reading('0, bcomp_pkg::RAW_ALL_ONES);
        wait_for_results();
    endtask

    task automatic test_extreme_values();
        for (int set = 0; set < 3; set++) begin
            case (set)
                0: load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: load_calibration(16'h0001, '0, '0, '0, '0, '0, '0);
                default: begin
                    load_calibration(16'h1234, TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
                    send_reading(TYP_D1, TYP_D2);
                end
            endcase
            send_reading(24'd1, 24'd1);
            send_reading(RAW_MAX_VALID, RAW_MAX_VALID);
            send_reading(24'd1, RAW_MAX_VALID);
            send_reading(RAW_MAX_VALID, 24'd1);
            wait_for_results();
        end
    endtask

    task automatic test_random_readings();
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            case (round)
                0: load_calibration(16'h0001, TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
                1: load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: load_calibration(16'h8000, '0, '0, '0, '0, '0, '0);
                default: load_calibration(16'($urandom_range(1, 65535)), pick_coef(),
                                          pick_coef(), pick_coef(), pick_coef(),
                                          pick_coef(), pick_coef());
            endcase
            case (round % 4)
                0:       set_idling(0, 0);
                1:       set_idling(65, 0);
                2:       set_idling(0, 65);
                default: set_idling(9, 9);
            endcase
            repeat (ROUND_ITEMS) send_reading(pick_pressure_raw(), pick_temperature_raw());
            wait_for_results();
        end
    endtask

    // long output stall: the pipeline fills up and has to stall its input
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_off_cycles = 200;
        repeat (32) send_reading(pick_pressure_raw(), pick_temperature_raw());
        wait_for_results();
    endtask

    task automatic test_pause_until_drained();
        set_idling(65, 65);
        repeat (12) send_reading(pick_pressure_raw(), pick_temperature_raw());
        wait_for_results();
        set_idling(0, 9);
        repeat (12) send_reading(pick_pressure_raw(), pick_temperature_raw());
        wait_for_results();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_uncalibrated();
        test_bad_register_index();
        test_invalid_readings();
        test_extreme_values();
        test_random_readings();
        test_output_backpressure();
        test_pause_until_drained();

        fail_count += compensated_q.size();
        if (fail_count == 0) begin
            $display("** baro_sensor_compensation_top: PASSED **");
        end else begin
            $display("** baro_sensor_compensation_top: FAILED **");
        end
        $finish;
    end

endmodule
